[design/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/sst_pkg.sv]
// Types and codes of the step sequencer.
package sst_pkg;

    localparam int IDX_W = 5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  step_addr;
        logic [2:0]  step_kind;
        logic [31:0] step_limit_ms;
        logic [7:0]  step_retry_budget;
        logic [31:0] step_argument;
        logic [31:0] now_ms;
        logic [1:0]  device_status;
        logic        client_present;
        logic        guard_pass;
    } in_item_t;

    typedef struct packed {
        logic        finished;
        logic [1:0]  final_status;
        logic [4:0]  current_step;
        logic [7:0]  retries_left;
        logic [2:0]  command_kind;
        logic [31:0] command_argument;
        logic [2:0]  failure_cause;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] limit_ms;
        logic [7:0]  retry_budget;
        logic [31:0] argument;
    } step_entry_t;

    // operations
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // step kinds
    localparam logic [2:0] KIND_ARM         = 3'd0;
    localparam logic [2:0] KIND_GRIPPER     = 3'd1;
    localparam logic [2:0] KIND_DELAY       = 3'd2;
    localparam logic [2:0] KIND_GUARD       = 3'd3;
    localparam logic [2:0] KIND_SERVO_START = 3'd4;
    localparam logic [2:0] KIND_SERVO_PAUSE = 3'd5;

    // device answers
    localparam logic [1:0] DEV_BUSY      = 2'd0;
    localparam logic [1:0] DEV_SUCCEEDED = 2'd1;
    localparam logic [1:0] DEV_FAILED    = 2'd2;
    localparam logic [1:0] DEV_TIMED_OUT = 2'd3;

    // commands
    localparam logic [2:0] CMD_NONE        = 3'd0;
    localparam logic [2:0] CMD_ARM_MOVE    = 3'd1;
    localparam logic [2:0] CMD_SET_GRIPPER = 3'd2;
    localparam logic [2:0] CMD_SERVO_START = 3'd3;
    localparam logic [2:0] CMD_SERVO_PAUSE = 3'd4;
    localparam logic [2:0] CMD_GUARD_QUERY = 3'd5;

    // final status
    localparam logic [1:0] STATUS_SUCCESS = 2'd0;
    localparam logic [1:0] STATUS_FAILURE = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // failure causes
    localparam logic [2:0] CAUSE_NONE           = 3'd0;
    localparam logic [2:0] CAUSE_STEP_TIMEOUT   = 3'd1;
    localparam logic [2:0] CAUSE_CLIENT_MISSING = 3'd2;
    localparam logic [2:0] CAUSE_DEVICE_FAILED  = 3'd3;
    localparam logic [2:0] CAUSE_DEVICE_TIMEOUT = 3'd4;
    localparam logic [2:0] CAUSE_GUARD_REJECTED = 3'd5;
    localparam logic [2:0] CAUSE_UNKNOWN_KIND   = 3'd6;
    localparam logic [2:0] CAUSE_GRIPPER_MISS   = 3'd7;

endpackage

[design/sst_step_ram.sv]
// Step table memory: one write port, one registered read port, write-to-read bypass.
module sst_step_ram #(
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  sst_pkg::step_entry_t                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output sst_pkg::step_entry_t                       rd_data
);

    sst_pkg::step_entry_t mem [DEPTH];
    sst_pkg::step_entry_t rd_data_reg;
    sst_pkg::step_entry_t fwd_data_reg;
    logic                 fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // a write to the row being read this cycle wins over the stale array word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

[design/step_sequencer_retry_timeout.sv]
// Top level of the command-step sequencer with per-step timeout and retries.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid / in_ready     | in_data  (sst_pkg::in_item_t)
//  out     | output    | out_valid / out_ready   | out_data (sst_pkg::out_item_t)
//  cfg     | input     | cfg_wr_en, no wait      | cfg_wr_data (step_count)
//
// One item per cycle unless stalled; results pass the execute and output stages.
// The step table is read every cycle at the index the next item will see,
// so the registered read of the table memory is hidden.
// Reset clears progress and step_count at once; the table is not cleared.
// A stalled output holds the execute stage, which in turn drops in_ready.
module step_sequencer_retry_timeout #(
    parameter int MAX_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sst_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sst_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data
);

`include "assert_macros.svh"

    localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // execute stage
    logic               exec_valid_reg;
    sst_pkg::in_item_t  item_reg;
    logic               exec_fire;

    // output stage
    logic               out_valid_reg;
    sst_pkg::out_item_t out_data_reg;
    sst_pkg::out_item_t out_next;

    // sequencer state
    logic [4:0]  step_count_reg;
    logic [4:0]  step_index_reg,  step_index_next;
    logic        step_entered_reg, step_entered_next;
    logic [7:0]  retry_reg,       retry_next;
    logic        done_reg,        done_next;
    logic [1:0]  status_reg,      status_next;
    logic [31:0] start_reg,       start_next;
    logic [2:0]  cause_reg,       cause_next;

    // table access
    sst_pkg::step_entry_t entry;
    sst_pkg::step_entry_t wr_entry;
    logic                 tbl_wr_en;

    // tick datapath
    logic [7:0]  eff_retry;
    logic [31:0] eff_start;
    logic [31:0] elapsed;
    logic        fail_en;
    logic        final_en;
    logic [2:0]  fail_cause;
    logic [1:0]  fail_status;
    logic        adv_en;
    logic [2:0]  cmd_kind;
    logic [31:0] cmd_arg;

    assign exec_fire = exec_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !exec_valid_reg || exec_fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign wr_entry.kind         = item_reg.step_kind;
    assign wr_entry.limit_ms     = item_reg.step_limit_ms;
    assign wr_entry.retry_budget = item_reg.step_retry_budget;
    assign wr_entry.argument     = item_reg.step_argument;
    assign tbl_wr_en = exec_fire && (item_reg.operation == sst_pkg::OP_WRITE)
                       && (32'(item_reg.step_addr) < 32'(MAX_STEPS));

    sst_step_ram #(
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (ADDR_W'(item_reg.step_addr)),
        .wr_data (wr_entry),
        .rd_addr (ADDR_W'(step_index_next)),
        .rd_data (entry)
    );

    // latch time and budget on entering a step
    assign eff_retry = step_entered_reg ? retry_reg : entry.retry_budget;
    assign eff_start = step_entered_reg ? start_reg : item_reg.now_ms;
    assign elapsed   = item_reg.now_ms - eff_start;

    // dispatch of one tick on the current step
    always_comb
    begin
        fail_en     = 1'b0;
        final_en    = 1'b0;
        fail_cause  = sst_pkg::CAUSE_NONE;
        fail_status = sst_pkg::STATUS_FAILURE;
        adv_en      = 1'b0;
        cmd_kind    = sst_pkg::CMD_NONE;
        cmd_arg     = 32'd0;
        if ((entry.limit_ms != 32'd0) && (elapsed >= entry.limit_ms))
        begin
            fail_en     = 1'b1;
            fail_cause  = sst_pkg::CAUSE_STEP_TIMEOUT;
            fail_status = sst_pkg::STATUS_TIMEOUT;
        end
        else
        begin
            case (entry.kind)
                sst_pkg::KIND_ARM, sst_pkg::KIND_SERVO_START, sst_pkg::KIND_SERVO_PAUSE:
                begin
                    if (!item_reg.client_present)
                    begin
                        fail_en    = 1'b1;
                        fail_cause = sst_pkg::CAUSE_CLIENT_MISSING;
                    end
                    else
                    begin
                        if (entry.kind == sst_pkg::KIND_ARM)
                        begin
                            cmd_kind = sst_pkg::CMD_ARM_MOVE;
                            cmd_arg  = entry.argument;
                        end
                        else if (entry.kind == sst_pkg::KIND_SERVO_START)
                        begin
                            cmd_kind = sst_pkg::CMD_SERVO_START;
                        end
                        else
                        begin
                            cmd_kind = sst_pkg::CMD_SERVO_PAUSE;
                        end
                        case (item_reg.device_status)
                            sst_pkg::DEV_SUCCEEDED:
                            begin
                                adv_en = 1'b1;
                            end
                            sst_pkg::DEV_FAILED:
                            begin
                                fail_en    = 1'b1;
                                fail_cause = sst_pkg::CAUSE_DEVICE_FAILED;
                            end
                            sst_pkg::DEV_TIMED_OUT:
                            begin
                                fail_en    = 1'b1;
                                fail_cause = sst_pkg::CAUSE_DEVICE_TIMEOUT;
                                // arm steps have no timeout answer of their own
                                fail_status = (entry.kind == sst_pkg::KIND_ARM)
                                              ? sst_pkg::STATUS_FAILURE
                                              : sst_pkg::STATUS_TIMEOUT;
                            end
                            default:
                            begin
                                adv_en = 1'b0;
                            end
                        endcase
                    end
                end
                sst_pkg::KIND_GRIPPER:
                begin
                    if (!item_reg.client_present)
                    begin
                        final_en   = 1'b1;
                        fail_cause = sst_pkg::CAUSE_GRIPPER_MISS;
                    end
                    else
                    begin
                        cmd_kind = sst_pkg::CMD_SET_GRIPPER;
                        cmd_arg  = entry.argument;
                        adv_en   = 1'b1;
                    end
                end
                sst_pkg::KIND_DELAY:
                begin
                    adv_en = (elapsed >= entry.argument);
                end
                sst_pkg::KIND_GUARD:
                begin
                    cmd_kind = sst_pkg::CMD_GUARD_QUERY;
                    cmd_arg  = entry.argument;
                    if (item_reg.guard_pass)
                    begin
                        adv_en = 1'b1;
                    end
                    else
                    begin
                        final_en   = 1'b1;
                        fail_cause = sst_pkg::CAUSE_GUARD_REJECTED;
                    end
                end
                default:
                begin
                    fail_en    = 1'b1;
                    fail_cause = sst_pkg::CAUSE_UNKNOWN_KIND;
                end
            endcase
        end
    end

    // next state of the sequencer for the item in the execute stage
    always_comb
    begin
        step_index_next   = step_index_reg;
        step_entered_next = step_entered_reg;
        retry_next        = retry_reg;
        done_next         = done_reg;
        status_next       = status_reg;
        start_next        = start_reg;
        cause_next        = cause_reg;
        out_next.command_kind     = sst_pkg::CMD_NONE;
        out_next.command_argument = 32'd0;
        if (exec_fire)
        begin
            case (item_reg.operation)
                sst_pkg::OP_RESTART:
                begin
                    step_index_next   = 5'd0;
                    step_entered_next = 1'b0;
                    retry_next        = 8'd0;
                    done_next         = 1'b0;
                    status_next       = sst_pkg::STATUS_SUCCESS;
                    start_next        = 32'd0;
                    cause_next        = sst_pkg::CAUSE_NONE;
                end
                sst_pkg::OP_TICK:
                begin
                    if (!done_reg)
                    begin
                        if ((32'(step_index_reg) >= 32'(MAX_STEPS))
                            || (step_index_reg >= step_count_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = sst_pkg::STATUS_SUCCESS;
                        end
                        else
                        begin
                            step_entered_next = 1'b1;
                            retry_next        = eff_retry;
                            start_next        = eff_start;
                            out_next.command_kind     = cmd_kind;
                            out_next.command_argument = cmd_arg;
                            if (fail_en)
                            begin
                                cause_next = fail_cause;
                                if (eff_retry != 8'd0)
                                begin
                                    // retry: spend one from the budget, restart the timer
                                    retry_next = eff_retry - 8'd1;
                                    start_next = item_reg.now_ms;
                                end
                                else
                                begin
                                    done_next   = 1'b1;
                                    status_next = fail_status;
                                end
                            end
                            else if (final_en)
                            begin
                                cause_next  = fail_cause;
                                done_next   = 1'b1;
                                status_next = sst_pkg::STATUS_FAILURE;
                            end
                            else if (adv_en)
                            begin
                                step_index_next   = step_index_reg + 5'd1;
                                step_entered_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    done_next = done_reg;
                end
            endcase
        end
        out_next.finished      = done_next;
        out_next.final_status  = status_next;
        out_next.current_step  = step_index_next;
        out_next.retries_left  = retry_next;
        out_next.failure_cause = cause_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            step_count_reg   <= 5'd0;
            step_index_reg   <= 5'd0;
            step_entered_reg <= 1'b0;
            retry_reg        <= 8'd0;
            done_reg         <= 1'b0;
            status_reg       <= sst_pkg::STATUS_SUCCESS;
            start_reg        <= 32'd0;
            cause_reg        <= sst_pkg::CAUSE_NONE;
        end
        else
        begin
            if (in_ready)
            begin
                exec_valid_reg <= in_valid;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                step_count_reg <= cfg_wr_data;
            end
            step_index_reg   <= step_index_next;
            step_entered_reg <= step_entered_next;
            retry_reg        <= retry_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            start_reg        <= start_next;
            cause_reg        <= cause_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
        if (exec_fire)
        begin
            out_data_reg <= out_next;
        end
    end

    `ASSERT_NEXT(a_done_sticky, done_reg && !(exec_fire && (item_reg.operation == sst_pkg::OP_RESTART)), done_reg, "sequence left the finished state without a restart")
    `ASSERT_SAME(a_cmd_only_running, exec_fire && (out_next.command_kind != sst_pkg::CMD_NONE), !done_reg && (item_reg.operation == sst_pkg::OP_TICK), "command issued outside a running tick")
    `ASSERT_NEXT(a_restart_clears, exec_fire && (item_reg.operation == sst_pkg::OP_RESTART), (step_index_reg == 5'd0) && (cause_reg == sst_pkg::CAUSE_NONE) && !done_reg, "restart did not clear progress")

endmodule
